@@ hw/rtl/acb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package acb_pkg;

    // one bgra pixel, blue in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    // per-item control that travels with the pixel through the stages
    typedef struct packed {
        logic emit;
        logic mask_top;
        logic mask_bot;
        logic mask_left;
        logic mask_right;
        logic last;
    } ctl_t;

    localparam int SUM_W       = 11;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 14;

    // ceil(2^14 / cnt), exact quotient for sums below 2048
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        begin
            case (cnt)
                4'd1:    m = 15'd16384;
                4'd2:    m = 15'd8192;
                4'd3:    m = 15'd5462;
                4'd4:    m = 15'd4096;
                4'd5:    m = 15'd3277;
                4'd6:    m = 15'd2731;
                4'd7:    m = 15'd2341;
                4'd8:    m = 15'd2048;
                default: m = 15'd0;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/acb_linebuf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acb_linebuf #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         ce,
    input  wire logic                         proc,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  wire acb_pkg::pix_t                px,
    output acb_pkg::pix_t                     up_q,
    output acb_pkg::pix_t                     mid_q
);
    import acb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    pix_t upper_mem [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];

    pix_t          up_reg;
    pix_t          mid_reg;
    logic          hold_v_reg;
    logic [AW-1:0] hold_x_reg;

    // pending upper-row write of the previous item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            hold_v_reg <= proc;
        end
    end

    // read both rows, shift middle into upper, forward on same address
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (proc)
            begin
                up_reg     <= (hold_v_reg && hold_x_reg == addr) ? mid_reg : upper_mem[addr];
                mid_reg    <= middle_mem[addr];
                middle_mem[addr] <= px;
                hold_x_reg <= addr;
            end
            if (hold_v_reg)
            begin
                upper_mem[hold_x_reg] <= mid_reg;
            end
        end
    end

    assign up_q  = up_reg;
    assign mid_q = mid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/acb_nbr_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acb_nbr_sum (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       ce,
    input  wire logic                       proc,
    input  wire acb_pkg::ctl_t              ctl,
    input  wire acb_pkg::pix_t              up,
    input  wire acb_pkg::pix_t              mid,
    input  wire acb_pkg::pix_t              px,
    output acb_pkg::ctl_t                   sum_ctl,
    output acb_pkg::pix_t                   centre,
    output logic [acb_pkg::SUM_W-1:0]       sum_b,
    output logic [acb_pkg::SUM_W-1:0]       sum_g,
    output logic [acb_pkg::SUM_W-1:0]       sum_r,
    output logic [acb_pkg::CNT_W-1:0]       cnt
);
    import acb_pkg::*;

    pix_t win_reg [9];
    ctl_t b_ctl_reg;
    ctl_t b_ctl_next;
    ctl_t c_ctl_reg;
    pix_t c_centre_reg;
    logic [SUM_W-1:0] sb_reg, sg_reg, sr_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [SUM_W-1:0] sb_next, sg_next, sr_next;
    logic [CNT_W-1:0] cnt_next;

    // only processed items may emit
    always_comb
    begin
        b_ctl_next      = ctl;
        b_ctl_next.emit = proc && ctl.emit;
    end

    // control valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
        end
        else if (ce)
        begin
            b_ctl_reg <= b_ctl_next;
            c_ctl_reg <= b_ctl_reg;
        end
    end

    // 3x3 window, shifts left by one column per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ce && proc)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= up;
            win_reg[5] <= mid;
            win_reg[8] <= px;
        end
    end

    // masked sums over the eight neighbors with nonzero alpha
    always_comb
    begin
        sb_next  = '0;
        sg_next  = '0;
        sr_next  = '0;
        cnt_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!(r == 1 && c == 1) &&
                    !(r == 0 && b_ctl_reg.mask_top) &&
                    !(r == 2 && b_ctl_reg.mask_bot) &&
                    !(c == 0 && b_ctl_reg.mask_left) &&
                    !(c == 2 && b_ctl_reg.mask_right) &&
                    win_reg[r*3+c].alpha != 8'd0)
                begin
                    sb_next  = sb_next + SUM_W'(win_reg[r*3+c].blue);
                    sg_next  = sg_next + SUM_W'(win_reg[r*3+c].green);
                    sr_next  = sr_next + SUM_W'(win_reg[r*3+c].red);
                    cnt_next = cnt_next + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sb_reg       <= sb_next;
            sg_reg       <= sg_next;
            sr_reg       <= sr_next;
            cnt_reg      <= cnt_next;
            c_centre_reg <= win_reg[4];
        end
    end

    assign sum_ctl = c_ctl_reg;
    assign centre  = c_centre_reg;
    assign sum_b   = sb_reg;
    assign sum_g   = sg_reg;
    assign sum_r   = sr_reg;
    assign cnt     = cnt_reg;

endmodule

`default_nettype wire

@@ hw/rtl/acb_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module acb_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       ce,
    input  wire acb_pkg::ctl_t              sum_ctl,
    input  wire acb_pkg::pix_t              centre,
    input  wire logic [acb_pkg::SUM_W-1:0]  sum_b,
    input  wire logic [acb_pkg::SUM_W-1:0]  sum_g,
    input  wire logic [acb_pkg::SUM_W-1:0]  sum_r,
    input  wire logic [acb_pkg::CNT_W-1:0]  cnt,
    output logic                            res_valid,
    output logic                            res_last,
    output acb_pkg::pix_t                   res_pix
);
    import acb_pkg::*;

    localparam int PW = SUM_W + RECIP_W;

    logic [RECIP_W-1:0] m;
    logic [PW-1:0]      pb, pg, pr;
    pix_t               pix_next;
    logic               v_reg;
    logic               last_reg;
    pix_t               pix_reg;

    // divide by 1..8 through the reciprocal table
    always_comb
    begin
        m        = recip(cnt);
        pb       = PW'(sum_b) * PW'(m);
        pg       = PW'(sum_g) * PW'(m);
        pr       = PW'(sum_r) * PW'(m);
        pix_next = centre;
        if (centre.alpha == 8'd0 && cnt != '0)
        begin
            pix_next.blue  = pb[RECIP_SHIFT +: 8];
            pix_next.green = pg[RECIP_SHIFT +: 8];
            pix_next.red   = pr[RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_reg <= sum_ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pix_reg  <= pix_next;
            last_reg <= sum_ctl.last;
        end
    end

    assign res_valid = v_reg;
    assign res_last  = last_reg;
    assign res_pix   = pix_reg;

endmodule

`default_nettype wire

@@ hw/rtl/alpha_edge_color_bleed_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Color bleed into fully transparent pixels over a 3x3 window. Pixels enter
// in raster order on s_* one per clock while s_tready is high; each pixel
// with alpha 0 takes the truncated average color of its in-image neighbors
// with nonzero alpha. Results leave on m_* one row plus one pixel behind the
// input, so every frame must be followed by frame_width+1 flush items
// (tuser = 1, or any item once the frame's pixels are in); m_tlast marks the
// last pixel. The block takes one item per cycle while s_tready is high;
// m_tvalid rises after the item passes the line-buffer read, window, sum,
// divide and output registers. Two line memories of MAX_WIDTH words hold the
// upper rows. Writing a register restarts the frame; input is held off while
// a write is offered and, after reset or a write, until the frame size
// product is registered.

module alpha_edge_color_bleed_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // in_blue, in_green, in_red, in_alpha
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_blue, out_green, out_red, out_alpha
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data
);
    import acb_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int TB = WB + HB;
    localparam int PB = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [11:0]   fw_reg;
    logic [12:0]   fh_reg;
    logic          tot_pend_reg;
    logic [PB-1:0] total_reg;
    logic [PB-1:0] pos_reg, pos_next;
    logic [WB-1:0] in_col_reg, in_col_next;
    logic [WB-1:0] out_col_reg, out_col_next;
    logic [HB-1:0] out_row_reg, out_row_next;

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic          ce, acc, cfg_wr, in_frame, proc;
    pix_t          px;
    ctl_t          ctl;
    logic          a_proc_reg;
    ctl_t          a_ctl_reg;
    pix_t          a_px_reg;
    pix_t          up_q, mid_q;

    ctl_t               sum_ctl;
    pix_t               centre;
    logic [SUM_W-1:0]   sum_b, sum_g, sum_r;
    logic [CNT_W-1:0]   cnt;
    logic               res_valid, res_last;
    pix_t               res_pix;

    logic               out_v_reg, skid_v_reg;
    logic               out_last_reg, skid_last_reg;
    pix_t               out_pix_reg, skid_pix_reg;

    // clamped frame size
    always_comb
    begin
        if (fw_reg == '0)
            w_eff = WB'(1);
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = WB'(fw_reg);
        if (fh_reg == '0)
            h_eff = HB'(1);
        else if (32'(fh_reg) > 32'(MAX_HEIGHT))
            h_eff = HB'(MAX_HEIGHT);
        else
            h_eff = HB'(fh_reg);
    end

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign ce        = !skid_v_reg;
    assign s_tready  = ce && !tot_pend_reg && !cfg_valid;
    assign acc       = s_tvalid && s_tready;
    assign in_frame  = pos_reg < total_reg;
    assign proc      = acc && !(in_frame && s_tuser);
    assign px        = in_frame ? pix_t'(s_tdata) : pix_t'('0);

    // position masks for the output pixel this item produces
    always_comb
    begin
        ctl.emit       = pos_reg >= (PB'(w_eff) + PB'(1));
        ctl.mask_top   = out_row_reg == '0;
        ctl.mask_bot   = (HB+1)'(out_row_reg) + (HB+1)'(1) >= (HB+1)'(h_eff);
        ctl.mask_left  = out_col_reg == '0;
        ctl.mask_right = (WB+1)'(out_col_reg) + (WB+1)'(1) >= (WB+1)'(w_eff);
        ctl.last       = ctl.mask_bot && ctl.mask_right;
    end

    // input and output position counters
    always_comb
    begin
        pos_next     = pos_reg;
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (proc)
        begin
            pos_next = pos_reg + PB'(1);
            if ((WB+1)'(in_col_reg) + (WB+1)'(1) >= (WB+1)'(w_eff))
                in_col_next = '0;
            else
                in_col_next = in_col_reg + WB'(1);
            if (ctl.emit)
            begin
                if (ctl.mask_right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HB'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + WB'(1);
                end
                if (ctl.last)
                begin
                    pos_next     = '0;
                    in_col_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
        if (cfg_wr)
        begin
            pos_next     = '0;
            in_col_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    // registers, counters and frame size product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg       <= 12'd640;
            fh_reg       <= 13'd480;
            tot_pend_reg <= 1'b1;
            pos_reg      <= '0;
            in_col_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end
        else
        begin
            tot_pend_reg <= cfg_wr;
            if (cfg_wr && cfg_index == REG_WIDTH)
                fw_reg <= cfg_data[11:0];
            if (cfg_wr && cfg_index == REG_HEIGHT)
                fh_reg <= cfg_data;
            pos_reg     <= pos_next;
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= PB'(TB'(w_eff) * TB'(h_eff));
    end

    // stage a: item alongside line buffer read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_proc_reg <= 1'b0;
            a_ctl_reg  <= '0;
        end
        else if (ce)
        begin
            a_proc_reg <= proc;
            a_ctl_reg  <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_px_reg <= px;
        end
    end

    acb_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .proc  (proc),
        .addr  (in_col_reg[AW-1:0]),
        .px    (px),
        .up_q  (up_q),
        .mid_q (mid_q)
    );

    acb_nbr_sum u_nbr_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .proc    (a_proc_reg),
        .ctl     (a_ctl_reg),
        .up      (up_q),
        .mid     (mid_q),
        .px      (a_px_reg),
        .sum_ctl (sum_ctl),
        .centre  (centre),
        .sum_b   (sum_b),
        .sum_g   (sum_g),
        .sum_r   (sum_r),
        .cnt     (cnt)
    );

    acb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .sum_ctl   (sum_ctl),
        .centre    (centre),
        .sum_b     (sum_b),
        .sum_g     (sum_g),
        .sum_r     (sum_r),
        .cnt       (cnt),
        .res_valid (res_valid),
        .res_last  (res_last),
        .res_pix   (res_pix)
    );

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!skid_v_reg)
        begin
            if (!out_v_reg || m_tready)
                out_v_reg <= res_valid;
            else
                skid_v_reg <= res_valid;
        end
        else if (m_tready)
        begin
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            if (!out_v_reg || m_tready)
            begin
                out_pix_reg  <= res_pix;
                out_last_reg <= res_last;
            end
            else
            begin
                skid_pix_reg  <= res_pix;
                skid_last_reg <= res_last;
            end
        end
        else if (m_tready)
        begin
            out_pix_reg  <= skid_pix_reg;
            out_last_reg <= skid_last_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ dv/alpha_edge_color_bleed_unit_tb.sv @@
`timescale 1ns / 1ps

module alpha_edge_color_bleed_unit_tb;
    import acb_pkg::*;

    localparam int MAX_W      = 2048;
    localparam int MAX_H      = 4096;
    localparam int CYCLE_CAP  = 900000;
    localparam int SETTLE     = 12;
    localparam bit REG_WIDTH  = 1'b0;
    localparam bit REG_HEIGHT = 1'b1;
    localparam bit OP_PIXEL   = 1'b0;
    localparam bit OP_FLUSH   = 1'b1;

    typedef struct {
        pix_t pix;
        bit   last;
    } bled_pixel_t;

    // bleed predictor plus queue of pixels still owed by the block
    class bleed_scoreboard;
        logic [31:0] upper_line [MAX_W];
        logic [31:0] middle_line [MAX_W];
        logic [31:0] win [9];
        int unsigned in_col, in_row, out_col, out_row;
        int unsigned width_reg, height_reg;
        bled_pixel_t owed [$];
        int errors;
        int checked;

        function new();
            foreach (upper_line[i])
            begin
                upper_line[i] = '0;
                middle_line[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            width_reg = 640;
            height_reg = 480;
            restart();
            errors = 0;
            checked = 0;
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_H) return MAX_H;
            return height_reg;
        endfunction

        function void write_reg(bit idx, logic [12:0] value);
            if (idx == REG_WIDTH) width_reg = value & 13'hfff;
            else height_reg = value;
            restart();
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // note one accepted item, queue the pixel it releases if any
        function void note_item(bit op, pix_t p);
            int unsigned w, h, total, pos, x, cnt, sb, sg, sr;
            logic [31:0] px, up, mid, n;
            bled_pixel_t res;
            w = eff_w();
            h = eff_h();
            total = w * h;
            pos = in_row * w + in_col;
            px = '0;
            x = in_col;
            cnt = 0;
            sb = 0;
            sg = 0;
            sr = 0;
            if (pos < total)
            begin
                // flush inside a frame is ignored
                if (op == OP_FLUSH) return;
                px = p;
            end
            if (x >= MAX_W) x = 0;
            up = upper_line[x];
            mid = middle_line[x];
            upper_line[x] = mid;
            middle_line[x] = px;
            for (int r = 0; r < 3; r++)
            begin
                win[r*3] = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (pos < w + 1) return;

            // sum in-image neighbors with nonzero alpha
            for (int r = 0; r < 3; r++)
            begin
                if (r == 0 && out_row == 0) continue;
                if (r == 2 && out_row + 1 >= h) continue;
                for (int c = 0; c < 3; c++)
                begin
                    if (r == 1 && c == 1) continue;
                    if (c == 0 && out_col == 0) continue;
                    if (c == 2 && out_col + 1 >= w) continue;
                    n = win[r*3+c];
                    if (n[31:24] != 0)
                    begin
                        sb += n[7:0];
                        sg += n[15:8];
                        sr += n[23:16];
                        cnt++;
                    end
                end
            end
            res.pix = win[4];
            if (res.pix.alpha == 0 && cnt > 0)
            begin
                res.pix.blue = 8'(sb / cnt);
                res.pix.green = 8'(sg / cnt);
                res.pix.red = 8'(sr / cnt);
            end
            res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
            owed.push_back(res);
            if (res.last) restart();
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        // compare one output pixel with the oldest owed one
        function void check_pixel(logic [31:0] data, logic last);
            bled_pixel_t want;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output item data=%h last=%b", data, last);
                return;
            end
            want = owed.pop_front();
            checked++;
            if (data !== want.pix || last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("item %0d: expected data=%h last=%b, got data=%h last=%b",
                             checked, want.pix, want.last, data, last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;

    bleed_scoreboard sb;
    int send_idle;
    int recv_stall;
    int cycles = 0;
    int frames;
    int pixels_sent;

    alpha_edge_color_bleed_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run cap
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("alpha_edge_color_bleed_unit: mismatch");
            $finish;
        end
    end

    // output side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic pix_t rand_pixel();
        pix_t p;
        p = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: p.alpha = 8'h00;
            4: p.alpha = 8'hff;
            5: p.alpha = 8'h01;
            6:
            begin
                p.blue = 8'hff;
                p.green = 8'hff;
                p.red = 8'hff;
            end
            7:
            begin
                p.blue = 8'h00;
                p.green = 8'h00;
                p.red = 8'h00;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_item(bit op, pix_t p);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        s_tuser <= op;
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, p);
    endtask

    // hold off until every owed pixel is out, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(bit idx, logic [12:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // flush ticks, some carrying pixel data that must be dropped
    task automatic send_flush(int noisy_pct);
        int n;
        n = sb.eff_w() + 1;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noisy_pct) send_item(OP_PIXEL, rand_pixel());
            else send_item(OP_FLUSH, rand_pixel());
        end
    endtask

    // one whole frame of random pixels with occasional stray flush ticks
    task automatic send_frame(int noise_pct);
        int n;
        n = sb.eff_w() * sb.eff_h();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noise_pct) send_item(OP_FLUSH, rand_pixel());
            send_item(OP_PIXEL, rand_pixel());
        end
        pixels_sent += n;
        send_flush(20);
        frames++;
    endtask

    task automatic set_size(logic [12:0] w, logic [12:0] h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    initial
    begin
        pix_t grid [9];
        int target;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        frames = 0;
        pixels_sent = 0;
        send_idle = 0;
        recv_stall = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed 3x3: opaque extremes, transparent pixels with and without color
        grid[0] = 32'hffffffff;
        grid[1] = 32'h00563412;
        grid[2] = 32'h01000000;
        grid[3] = 32'h00ffffff;
        grid[4] = 32'h00000000;
        grid[5] = 32'h80f00f55;
        grid[6] = 32'h00123456;
        grid[7] = 32'hff010203;
        grid[8] = 32'h00aabbcc;
        set_size(13'd3, 13'd3);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4) send_item(OP_FLUSH, 32'hdeadbeef);
            send_item(OP_PIXEL, grid[i]);
        end
        send_flush(50);
        frames++;

        // restart in mid frame by a register write
        for (int i = 0; i < 5; i++) send_item(OP_PIXEL, grid[8 - i]);
        write_reg(REG_HEIGHT, 13'd2);
        for (int i = 0; i < 6; i++) send_item(OP_PIXEL, grid[i]);
        send_flush(0);
        frames++;

        // single transparent pixel, zero registers act as one
        set_size(13'd0, 13'd0);
        send_item(OP_PIXEL, 32'h00a5a5a5);
        send_flush(0);
        frames++;

        // random frames over the idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 67;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 67;
                end
                default:
                begin
                    send_idle = 17;
                    recv_stall = 17;
                end
            endcase
            target = pixels_sent + 150;
            while (pixels_sent < target)
            begin
                if ($urandom_range(9) == 0)
                    set_size(13'($urandom_range(20)), 13'($urandom_range(8)));
                else
                    set_size(13'($urandom_range(1, 6)), 13'($urandom_range(1, 5)));
                send_frame(5);
            end
        end

        // wind down
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d frames, %0d pixels, %0d output items checked",
                 frames, pixels_sent, sb.checked);
        $display("sizes from 1x1 up to 20x8 incl. zero registers, stray flushes, restarts");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("alpha_edge_color_bleed_unit: match");
        else
            $display("alpha_edge_color_bleed_unit: mismatch");
        $finish;
    end

endmodule
